// File: rtl/gdc_pkg.sv
// shared types and constants for the gaze dwell click block
`default_nettype none
package gdc_pkg;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 8;
    localparam int FIX_BITS    = COORD_BITS + FRAC_BITS;
    localparam int COEF_BITS   = 16;
    localparam int CNT_BITS    = 9;
    localparam int LIMIT_BITS  = 8;
    localparam int RADIUS_BITS = 6;
    localparam int KIND_BITS   = 2;

    localparam logic [COEF_BITS-1:0] COEF_TAKE = 16'd3277;
    localparam logic [COEF_BITS-1:0] COEF_HALF = 16'd32768;

    // width / 3 as multiply by reciprocal and shift
    localparam int THIRD_SHIFT = COORD_BITS + 1;
    localparam int THIRD_MUL   = (2 ** THIRD_SHIFT + 2) / 3;
    localparam int THIRD_MBITS = THIRD_SHIFT;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;
    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 32;

    typedef enum logic [2:0] {
        REG_WIN_LEFT     = 3'd0,
        REG_WIN_TOP      = 3'd1,
        REG_WIN_WIDTH    = 3'd2,
        REG_WIN_HEIGHT   = 3'd3,
        REG_DWELL_LIMIT  = 3'd4,
        REG_STILL_RADIUS = 3'd5
    } t_reg_index;

    typedef enum logic [KIND_BITS-1:0] {
        REGION_SINGLE = 2'd0,
        REGION_DOUBLE = 2'd1,
        REGION_RIGHT  = 2'd2
    } t_region;

    localparam logic [KIND_BITS-1:0] CLICK_NONE  = 2'd0;
    localparam logic [KIND_BITS-1:0] CLICK_RIGHT = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0]  win_left;
        logic [COORD_BITS-1:0]  win_top;
        logic [COORD_BITS-1:0]  win_width;
        logic [COORD_BITS-1:0]  win_height;
        logic [LIMIT_BITS-1:0]  dwell_limit;
        logic [RADIUS_BITS-1:0] still_radius;
        logic [COORD_BITS-1:0]  third;
    } t_cfg;

    typedef struct packed {
        logic [FIX_BITS-1:0] smooth_x;
        logic [FIX_BITS-1:0] smooth_y;
        logic [FIX_BITS-1:0] prior_x;
        logic [FIX_BITS-1:0] prior_y;
    } t_point;

endpackage
`default_nettype wire

// File: rtl/gaze_dwell_click_top.sv
// top level of the gaze dwell click block
//
// channel   dir  handshake               payload
// s stream  in   i_s_tvalid/o_s_tready   tdata x,y; tuser sample_valid
// m stream  out  o_m_tvalid/i_m_tready   tdata cursor_x,cursor_y,click_kind,region
// apb cfg   in   psel/penable, pready=1  six window and dwell registers
//
// an item passes the smoothing stage (one 21x17 multiply per axis) into the
// point register, then the still test and dwell logic (two 14-bit squares
// and a compare) feeding the result register
// one item per cycle sustained; a stalled output holds the result register,
// the smoothing stage then holds its item and o_s_tready drops
// reset is synchronous, active low, and restores all registers but the result data register to defaults
`default_nettype none
module gaze_dwell_click_top
    import gdc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    input  wire logic [IN_DATA_BITS-1:0]  i_s_tdata,   // sample_x, sample_y
    input  wire logic                     i_s_tuser,   // sample_valid
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    output logic [OUT_DATA_BITS-1:0]      o_m_tdata,   // cursor_x, cursor_y, click_kind, region
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_BITS-1:0]     paddr,
    input  wire logic [DATA_BITS-1:0]     pwdata,
    output logic      [DATA_BITS-1:0]     prdata,
    output logic                          pready
);

    t_cfg   cfg;
    t_point point;
    logic   r_stage_valid;
    logic   advance;
    logic   load;

    assign advance    = r_stage_valid && (!o_m_tvalid || i_m_tready);
    assign o_s_tready = !r_stage_valid || advance;
    assign load       = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (load) begin
            r_stage_valid <= 1'b1;
        end else if (advance) begin
            r_stage_valid <= 1'b0;
        end
    end

    gdc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gdc_smooth u_smooth (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .i_sample_valid (i_s_tuser),
        .i_sample_x     (i_s_tdata[COORD_BITS-1:0]),
        .i_sample_y     (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .o_point        (point)
    );

    gdc_dwell u_dwell (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_m_tready (i_m_tready),
        .i_point    (point),
        .i_cfg      (cfg),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
`default_nettype wire

// File: rtl/gdc_cfg.sv
// apb configuration registers and derived window third
`default_nettype none
module gdc_cfg
    import gdc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    output t_cfg                      o_cfg
);

    logic [COORD_BITS-1:0]  r_win_left;
    logic [COORD_BITS-1:0]  r_win_top;
    logic [COORD_BITS-1:0]  r_win_width;
    logic [COORD_BITS-1:0]  r_win_height;
    logic [LIMIT_BITS-1:0]  r_dwell_limit;
    logic [RADIUS_BITS-1:0] r_still_radius;
    logic [COORD_BITS-1:0]  r_third;
    logic [COORD_BITS-1:0]  n_third;
    logic [COORD_BITS+THIRD_MBITS-1:0] third_prod;
    logic                   wr_en;
    t_reg_index             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_index'(paddr[ADDR_BITS-1:2]);

    assign third_prod = r_win_width * THIRD_MBITS'(THIRD_MUL);
    assign n_third    = third_prod[THIRD_SHIFT +: COORD_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left     <= '0;
            r_win_top      <= '0;
            r_win_width    <= COORD_BITS'(1024);
            r_win_height   <= COORD_BITS'(768);
            r_dwell_limit  <= LIMIT_BITS'(120);
            r_still_radius <= RADIUS_BITS'(5);
            r_third        <= COORD_BITS'(341);
        end else begin
            r_third <= n_third;
            if (wr_en) begin
                unique case (reg_idx)
                    REG_WIN_LEFT:     r_win_left     <= pwdata[COORD_BITS-1:0];
                    REG_WIN_TOP:      r_win_top      <= pwdata[COORD_BITS-1:0];
                    REG_WIN_WIDTH:    r_win_width    <= pwdata[COORD_BITS-1:0];
                    REG_WIN_HEIGHT:   r_win_height   <= pwdata[COORD_BITS-1:0];
                    REG_DWELL_LIMIT:  r_dwell_limit  <= pwdata[LIMIT_BITS-1:0];
                    REG_STILL_RADIUS: r_still_radius <= pwdata[RADIUS_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIN_LEFT:     prdata = DATA_BITS'(r_win_left);
            REG_WIN_TOP:      prdata = DATA_BITS'(r_win_top);
            REG_WIN_WIDTH:    prdata = DATA_BITS'(r_win_width);
            REG_WIN_HEIGHT:   prdata = DATA_BITS'(r_win_height);
            REG_DWELL_LIMIT:  prdata = DATA_BITS'(r_dwell_limit);
            REG_STILL_RADIUS: prdata = DATA_BITS'(r_still_radius);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = '{
        win_left:     r_win_left,
        win_top:      r_win_top,
        win_width:    r_win_width,
        win_height:   r_win_height,
        dwell_limit:  r_dwell_limit,
        still_radius: r_still_radius,
        third:        r_third
    };

endmodule
`default_nettype wire

// File: rtl/gdc_smooth.sv
// exponential smoothing stage holding smoothed and prior gaze points
`default_nettype none
module gdc_smooth
    import gdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire logic                  i_sample_valid,
    input  wire logic [COORD_BITS-1:0] i_sample_x,
    input  wire logic [COORD_BITS-1:0] i_sample_y,
    output t_point                     o_point
);

    localparam int PROD_BITS = FIX_BITS + COEF_BITS + 2;
    localparam logic signed [PROD_BITS-1:0] HALF = PROD_BITS'(COEF_HALF);
    localparam logic signed [COEF_BITS:0]   TAKE = {1'b0, COEF_TAKE};

    // old + take * (sample - old), rounded half up
    function automatic logic [FIX_BITS-1:0] f_blend(
        input logic [FIX_BITS-1:0]   old,
        input logic [COORD_BITS-1:0] smp
    );
        logic signed [FIX_BITS:0]    diff;
        logic signed [PROD_BITS-1:0] prod;
        logic signed [PROD_BITS-1:0] step;
        diff = $signed({1'b0, smp, {FRAC_BITS{1'b0}}}) - $signed({1'b0, old});
        prod = diff * TAKE;
        step = (prod + HALF) >>> COEF_BITS;
        return old + step[FIX_BITS-1:0];
    endfunction

    t_point r_point;
    t_point n_point;

    always_comb begin
        n_point = r_point;
        if (i_load && i_sample_valid) begin
            n_point.prior_x  = r_point.smooth_x;
            n_point.prior_y  = r_point.smooth_y;
            n_point.smooth_x = f_blend(r_point.smooth_x, i_sample_x);
            n_point.smooth_y = f_blend(r_point.smooth_y, i_sample_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point <= '0;
        end else begin
            r_point <= n_point;
        end
    end

    assign o_point = r_point;

endmodule
`default_nettype wire

// File: rtl/gdc_dwell.sv
// still test, dwell counter, click and region selection, result register
`default_nettype none
module gdc_dwell
    import gdc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_advance,
    input  wire logic                     i_m_tready,
    input  wire t_point                   i_point,
    input  wire t_cfg                     i_cfg,
    output logic                          o_m_tvalid,
    output logic [OUT_DATA_BITS-1:0]      o_m_tdata
);

    localparam int RAD_BITS = RADIUS_BITS + FRAC_BITS;
    localparam int SQ_BITS  = 2 * RAD_BITS;
    localparam int EDGE_BITS = COORD_BITS + 1;

    logic                     r_valid;
    logic [OUT_DATA_BITS-1:0] r_data;
    logic [CNT_BITS-1:0]      r_count;
    logic [CNT_BITS-1:0]      n_count;
    t_region                  r_region;
    t_region                  n_region;
    logic [KIND_BITS-1:0]     click;

    logic [FIX_BITS-1:0]      dx, dy;
    logic [RAD_BITS-1:0]      rad;
    logic [SQ_BITS-1:0]       dx2, dy2;
    logic [SQ_BITS:0]         dist2;
    logic [SQ_BITS-1:0]       rad2;
    logic [2*RADIUS_BITS-1:0] rad_sq;
    logic                     near, still, fire, in_win;
    logic [EDGE_BITS-1:0]     rgt, bot, cut_a, cut_b;

    assign dx = (i_point.prior_x > i_point.smooth_x) ? i_point.prior_x - i_point.smooth_x
                                                     : i_point.smooth_x - i_point.prior_x;
    assign dy = (i_point.prior_y > i_point.smooth_y) ? i_point.prior_y - i_point.smooth_y
                                                     : i_point.smooth_y - i_point.prior_y;
    assign rad    = {i_cfg.still_radius, {FRAC_BITS{1'b0}}};
    assign near   = (dx < FIX_BITS'(rad)) && (dy < FIX_BITS'(rad));
    assign dx2    = dx[RAD_BITS-1:0] * dx[RAD_BITS-1:0];
    assign dy2    = dy[RAD_BITS-1:0] * dy[RAD_BITS-1:0];
    assign dist2  = {1'b0, dx2} + {1'b0, dy2};
    assign rad_sq = i_cfg.still_radius * i_cfg.still_radius;
    assign rad2   = {rad_sq, {(2 * FRAC_BITS){1'b0}}};
    assign still  = near && (dist2 < {1'b0, rad2});
    assign fire   = still && (r_count > CNT_BITS'(i_cfg.dwell_limit));

    assign rgt   = {1'b0, i_cfg.win_left} + {1'b0, i_cfg.win_width};
    assign bot   = {1'b0, i_cfg.win_top} + {1'b0, i_cfg.win_height};
    assign cut_a = {1'b0, i_cfg.win_left} + {1'b0, i_cfg.third};
    assign cut_b = cut_a + {1'b0, i_cfg.third};

    always_comb begin
        in_win = ({i_point.smooth_x} > {i_cfg.win_left, {FRAC_BITS{1'b0}}})
              && ({1'b0, i_point.smooth_x} < {rgt, {FRAC_BITS{1'b0}}})
              && ({i_point.smooth_y} > {i_cfg.win_top, {FRAC_BITS{1'b0}}})
              && ({1'b0, i_point.smooth_y} < {bot, {FRAC_BITS{1'b0}}});
    end

    always_comb begin
        n_count  = '0;
        n_region = r_region;
        click    = CLICK_NONE;
        if (still) begin
            if (fire) begin
                click = (r_region == REGION_RIGHT) ? CLICK_RIGHT : KIND_BITS'(r_region) + 1'b1;
                if (in_win) begin
                    if ({1'b0, i_point.smooth_x} < {cut_a, {FRAC_BITS{1'b0}}}) begin
                        n_region = REGION_SINGLE;
                    end else if ({1'b0, i_point.smooth_x} < {cut_b, {FRAC_BITS{1'b0}}}) begin
                        n_region = REGION_DOUBLE;
                    end else begin
                        n_region = REGION_RIGHT;
                    end
                end
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_count  <= '0;
            r_region <= REGION_SINGLE;
        end else if (i_advance) begin
            r_valid  <= 1'b1;
            r_count  <= n_count;
            r_region <= n_region;
        end else if (i_m_tready) begin
            r_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_data <= OUT_DATA_BITS'({n_region, click,
                                      i_point.smooth_y[FIX_BITS-1:FRAC_BITS],
                                      i_point.smooth_x[FIX_BITS-1:FRAC_BITS]});
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule
`default_nettype wire
